FILE: rtl/core/kwm_pkg.sv
// shared constants, codes and handshake types for the k-way sorted merge
package kwm_pkg;

	localparam int LISTS     = 8;
	localparam int DEPTH     = 64;
	localparam int ID_W      = 3;
	localparam int VAL_W     = 16;
	localparam int CFG_W     = 4;
	localparam int SLOT_W    = $clog2(DEPTH);
	localparam int PTR_W     = SLOT_W + 1;
	localparam int LIDX_W    = $clog2(LISTS);
	localparam int ADDR_W    = LIDX_W + SLOT_W;
	localparam int MEM_WORDS = LISTS * DEPTH;

	localparam logic [CFG_W-1:0] LIU_RESET = CFG_W'(8);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOT_ASC  = 2'd2,
		ST_EMPTY    = 2'd3
	} kwm_status_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic load_head;
	} kwm_cmd_t;

	typedef struct packed {
		logic pop_hit;
	} kwm_stat_t;

endpackage

FILE: rtl/core/kwm_ctrl.sv
// request sequencer for the k-way sorted merge
module kwm_ctrl
	import kwm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  kwm_stat_t stat,
	output kwm_cmd_t  cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_LOAD
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd.load      = (state_q == S_IDLE) && start;
		cmd.exec      = (state_q == S_EXEC);
		cmd.load_head = (state_q == S_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= S_EXEC;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					done_q <= 1'b1;
					if (stat.pop_hit) begin
						state_q <= S_LOAD;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_LOAD: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

FILE: rtl/core/kwm_datapath.sv
// list storage, head registers, minimum search and result registers
module kwm_datapath
	import kwm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  kwm_cmd_t                cmd,
	output kwm_stat_t               stat,
	input  logic                    op,
	input  logic [ID_W-1:0]         list_id,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    cfg_we,
	input  logic [CFG_W-1:0]        cfg_data,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] merged_value,
	output logic [ID_W-1:0]         source_list
);

	logic                    op_q;
	logic [ID_W-1:0]         lid_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CFG_W-1:0]        liu_q;

	logic [PTR_W-1:0]        rptr_q [LISTS];
	logic [PTR_W-1:0]        wptr_q [LISTS];
	logic signed [VAL_W-1:0] last_q [LISTS];
	logic signed [VAL_W-1:0] head_q [LISTS];

	logic signed [VAL_W-1:0] mem [MEM_WORDS];
	logic signed [VAL_W-1:0] rdata_q;
	logic [LIDX_W-1:0]       best_q;

	kwm_status_t             status_q;
	logic signed [VAL_W-1:0] mval_q;
	logic [ID_W-1:0]         src_q;

	logic [LIDX_W-1:0]       pidx;
	logic [PTR_W-1:0]        pfill;
	logic                    lid_ok;
	logic                    p_full;
	logic                    p_empty;
	logic                    p_lower;
	logic                    push_ok;

	logic                    found;
	logic [LIDX_W-1:0]       best;
	logic signed [VAL_W-1:0] best_val;
	logic [PTR_W-1:0]        rptr_next;
	logic [ADDR_W-1:0]       raddr;
	logic [ADDR_W-1:0]       waddr;

	always_comb begin
		pidx    = lid_q[LIDX_W-1:0];
		lid_ok  = (32'(lid_q) < LISTS);
		pfill   = wptr_q[pidx] - rptr_q[pidx];
		p_full  = (32'(pfill) >= DEPTH);
		p_empty = (pfill == '0);
		p_lower = (val_q < last_q[pidx]);
		push_ok = lid_ok && !p_full && (p_empty || !p_lower);
		waddr   = {pidx, wptr_q[pidx][SLOT_W-1:0]};
	end

	// ordered search, lower list wins on ties
	always_comb begin
		found    = 1'b0;
		best     = '0;
		best_val = '0;
		for (int l = 0; l < LISTS; l++) begin
			if ((32'(liu_q) > l) && (wptr_q[l] != rptr_q[l])) begin
				if (!found || (head_q[l] < best_val)) begin
					found    = 1'b1;
					best     = LIDX_W'(l);
					best_val = head_q[l];
				end
			end
		end
		rptr_next = rptr_q[best] + PTR_W'(1);
		raddr     = {best, rptr_next[SLOT_W-1:0]};
	end

	assign stat.pop_hit = (op_q == OP_POP) && found;

	always_ff @(posedge clk) begin
		if (cmd.exec && (op_q == OP_PUSH) && push_ok)
			mem[waddr] <= val_q;
		if (cmd.exec && (op_q == OP_POP))
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			lid_q <= list_id;
			val_q <= value;
		end
		if (cmd.exec && (op_q == OP_PUSH) && push_ok) begin
			last_q[pidx] <= val_q;
			if (p_empty)
				head_q[pidx] <= val_q;
		end
		if (cmd.exec)
			best_q <= best;
		if (cmd.load_head)
			head_q[best_q] <= rdata_q;
		if (cmd.exec) begin
			if (op_q == OP_PUSH) begin
				mval_q <= '0;
				src_q  <= '0;
				if (!lid_ok || p_full)
					status_q <= ST_FULL;
				else if (!push_ok)
					status_q <= ST_NOT_ASC;
				else
					status_q <= ST_OK;
			end else if (found) begin
				status_q <= ST_OK;
				mval_q   <= best_val;
				src_q    <= ID_W'(best);
			end else begin
				status_q <= ST_EMPTY;
				mval_q   <= '0;
				src_q    <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			liu_q <= LIU_RESET;
			for (int l = 0; l < LISTS; l++) begin
				rptr_q[l] <= '0;
				wptr_q[l] <= '0;
			end
		end else begin
			if (cfg_we)
				liu_q <= cfg_data;
			if (cmd.exec && (op_q == OP_PUSH) && push_ok)
				wptr_q[pidx] <= wptr_q[pidx] + PTR_W'(1);
			if (cmd.exec && (op_q == OP_POP) && found)
				rptr_q[best] <= rptr_next;
		end
	end

	assign status       = status_q;
	assign merged_value = mval_q;
	assign source_list  = src_q;

endmodule

FILE: rtl/core/k_way_sorted_merge.sv
// top level of the k-way sorted merge
//
// keeps eight ascending lists of 64 signed 16-bit values in one 512-word memory
// a request is taken when start is high and busy is low; op selects push or pop
// push appends value to list list_id, checked for room and ascending order
// pop removes the smallest head among lists 0 .. lists_in_use-1, ties to the lower list
// each request gives one result: done is high for exactly one cycle with
// status, merged_value and source_list valid in that same cycle
// the accepting edge registers the request, and done rises together with the result
// registers at the end of the execute state, for push and pop alike
// a push, or a pop that finds every list empty, runs the execute state; a pop that
// removes a value also runs a load state, which loads the next head of the winning list
// from the memory's registered read port; the head search over the eight head
// registers is combinational; cfg_ready is always high; cfg_data sets lists_in_use,
// which the user must write only while idle; the block does not enforce this; reset
// clears all pointers, so every list is empty, and sets lists_in_use to 8
// no clearing pass is needed; the receiver cannot stall and must take done at once
module k_way_sorted_merge
	import kwm_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    op,
	input  logic [ID_W-1:0]         list_id,
	input  logic signed [VAL_W-1:0] value,
	output logic                    done,
	output logic [1:0]              status,
	output logic signed [VAL_W-1:0] merged_value,
	output logic [ID_W-1:0]         source_list,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_W-1:0]        cfg_data
);

	kwm_cmd_t  cmd;
	kwm_stat_t stat;

	assign cfg_ready = 1'b1;

	kwm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	kwm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.list_id      (list_id),
		.value        (value),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.status       (status),
		.merged_value (merged_value),
		.source_list  (source_list)
	);

endmodule

FILE: rtl/core/kwm_checker.sv
// port-level checks for the k-way sorted merge and their bind
module kwm_checker
	import kwm_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    start,
	input logic                    busy,
	input logic                    done,
	input logic [1:0]              status,
	input logic signed [VAL_W-1:0] merged_value,
	input logic [ID_W-1:0]         source_list
);

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("request without result two cycles later");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after accepted request");

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> ((merged_value == '0) && (source_list == '0)))
		else $error("failed request returned nonzero payload");

endmodule

bind k_way_sorted_merge kwm_checker u_kwm_checker (.*);
